### hw/rtl/sfs_pkg.sv
package sfs_pkg;

  // Field widths fixed by the interface definition.
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CELL_W   = 8;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned ORIGIN_W = 16;
  localparam int unsigned LOOP_W   = 16;
  localparam int unsigned SRC_W    = 20;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned MAX_FRAMES_DEF = 64;

  // Register values after reset, and the loop counter's saturation value.
  localparam logic [LOOP_W-1:0]   LOOP_LIMIT_RST  = 16'd1;
  localparam logic [SIZE_W-1:0]   CELL_SIZE_RST   = 11'd16;
  localparam logic [LOOP_W-1:0]   LOOP_SAT        = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOP_LIMIT     = 3'd0,
    CFG_LOOP_ENDLESS   = 3'd1,
    CFG_SHEET_ORIGIN_X = 3'd2,
    CFG_SHEET_ORIGIN_Y = 3'd3,
    CFG_CELL_WIDTH     = 3'd4,
    CFG_CELL_HEIGHT    = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_ADD  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_READ,
    S_MULX,
    S_MULY,
    S_FIN
  } seq_state_t;

  // One frame of the table.
  typedef struct packed {
    logic              flp;
    logic [TIME_W-1:0] dur;
    logic [CELL_W-1:0] row;
    logic [CELL_W-1:0] col;
  } entry_t;

  // One result word.
  typedef struct packed {
    logic             running;
    logic             rect_update;
    logic [SRC_W-1:0] src_x;
    logic [SRC_W-1:0] src_y;
    logic             flip;
    logic             table_full;
  } result_t;

endpackage

### hw/rtl/sfs_if.sv
interface sfs_in_if
  import sfs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  logic [TIME_W-1:0] delta_time;
  logic [CELL_W-1:0] cell_col;
  logic [CELL_W-1:0] cell_row;
  logic [TIME_W-1:0] frame_duration;
  logic              frame_flip;

  modport source (
    output valid, command, delta_time, cell_col, cell_row, frame_duration, frame_flip,
    input  ready
  );
  modport sink (
    input  valid, command, delta_time, cell_col, cell_row, frame_duration, frame_flip,
    output ready
  );
endinterface

interface sfs_out_if
  import sfs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             running;
  logic             rect_update;
  logic [SRC_W-1:0] src_x;
  logic [SRC_W-1:0] src_y;
  logic             flip;
  logic             table_full;

  modport source (
    output valid, running, rect_update, src_x, src_y, flip, table_full,
    input  ready
  );
  modport sink (
    input  valid, running, rect_update, src_x, src_y, flip, table_full,
    output ready
  );
endinterface

### hw/rtl/sprite_frame_sequencer.sv
// Sprite-sheet frame sequencer. Each input word is either an append, which adds one
// frame (cell column, cell row, Q16.16 duration, flip) to a table of MAX_FRAMES entries,
// or a tick, which advances the animation by delta_time and returns the current frame's
// source origin whenever that frame's timer was zero. Every input word produces exactly
// one result word. The block takes one word at a time. An append passes through the add
// and finish states, a tick that emits no origin through the read and finish states, and a
// tick that emits an origin through the read, x multiply, y multiply and finish states,
// because the x and y origins are computed one after the other on a single shared
// multiply-add unit. The result is loaded in the finish state, after which the next word
// can be taken. The table has one write port and one registered read port; the read is
// issued when a word is accepted and used in the read state. The result sits in an output
// register, so the block is ready for the next word while the last result waits to be
// taken; only when a second result is finished before the first has left does the block
// hold. The table has no reset and needs no clearing pass, since entries at or above the
// frame count are never used. The user must write configuration registers through
// cfg_we, cfg_index and cfg_data while no word is in flight; the block does not enforce it.
module sprite_frame_sequencer
  import sfs_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sfs_in_if.sink               in_ch,
  sfs_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Table index and frame count widths follow the table depth.
  localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAMES);

  // Configuration registers.
  logic [LOOP_W-1:0]   loop_limit_r;
  logic                loop_endless_r;
  logic [ORIGIN_W-1:0] origin_x_r;
  logic [ORIGIN_W-1:0] origin_y_r;
  logic [SIZE_W-1:0]   cell_w_r;
  logic [SIZE_W-1:0]   cell_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_limit_r   <= LOOP_LIMIT_RST;
      loop_endless_r <= 1'b0;
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      cell_w_r       <= CELL_SIZE_RST;
      cell_h_r       <= CELL_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOOP_LIMIT:     loop_limit_r   <= cfg_data[LOOP_W-1:0];
        CFG_LOOP_ENDLESS:   loop_endless_r <= cfg_data[0];
        CFG_SHEET_ORIGIN_X: origin_x_r     <= cfg_data[ORIGIN_W-1:0];
        CFG_SHEET_ORIGIN_Y: origin_y_r     <= cfg_data[ORIGIN_W-1:0];
        CFG_CELL_WIDTH:     cell_w_r       <= cfg_data[SIZE_W-1:0];
        CFG_CELL_HEIGHT:    cell_h_r       <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and animation state.
  seq_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    index_r, index_nxt;
  logic [TIME_W-1:0]   timer_r, timer_nxt;
  logic [LOOP_W-1:0]   loops_r, loops_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Latched input word, working result and output register.
  logic [TIME_W-1:0]   delta_r;
  entry_t              new_ent_r;
  result_t             res_r, res_nxt;
  result_t             out_res_r, out_res_nxt;

  // Frame table, one write port and one registered read port.
  entry_t              mem [MAX_FRAMES];
  entry_t              rdata_r;
  logic                mem_we;

  logic                in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= new_ent_r;
    end
    if (in_fire) begin
      rdata_r <= mem[index_r];
    end
  end

  // Shared multiply-add: origin plus cell size times cell position, x then y.
  logic [SIZE_W-1:0]   mul_a;
  logic [CELL_W-1:0]   mul_b;
  logic [ORIGIN_W-1:0] mul_base;
  logic [SRC_W-1:0]    mac;

  always_comb begin
    if (state_r == S_MULX) begin
      mul_a    = cell_w_r;
      mul_b    = rdata_r.col;
      mul_base = origin_x_r;
    end else begin
      mul_a    = cell_h_r;
      mul_b    = rdata_r.row;
      mul_base = origin_y_r;
    end
    mac = SRC_W'(mul_base) + SRC_W'(mul_a) * SRC_W'(mul_b);
  end

  // Timer add with saturation and the end-of-frame compare.
  logic [TIME_W:0]     sum_wide;
  logic [TIME_W-1:0]   timer_sum;
  logic                frame_done;
  logic                last_frame;
  logic                tick_active;
  logic [CNT_W-1:0]    add_count;
  logic                add_full;

  always_comb begin
    sum_wide    = {1'b0, timer_r} + {1'b0, delta_r};
    timer_sum   = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];
    frame_done  = (timer_sum >= rdata_r.dur);
    last_frame  = ((CNT_W'(index_r) + CNT_W'(1)) >= count_r);
    tick_active = (count_r != '0) && (loop_endless_r || (loops_r < loop_limit_r))
                  && (CNT_W'(index_r) < count_r);
    add_full    = (count_r >= CNT_MAX);
    add_count   = add_full ? count_r : count_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      index_r     <= '0;
      timer_r     <= '0;
      loops_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      index_r     <= index_nxt;
      timer_r     <= timer_nxt;
      loops_r     <= loops_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      delta_r       <= in_ch.delta_time;
      new_ent_r.col <= in_ch.cell_col;
      new_ent_r.row <= in_ch.cell_row;
      new_ent_r.dur <= in_ch.frame_duration;
      new_ent_r.flp <= in_ch.frame_flip;
    end
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    index_nxt     = index_r;
    timer_nxt     = timer_r;
    loops_nxt     = loops_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mem_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          state_nxt = (cmd_t'(in_ch.command) == CMD_ADD) ? S_ADD : S_READ;
        end
      end
      S_ADD: begin
        // The append lands at the current count unless the table is already full.
        mem_we             = !add_full;
        count_nxt          = add_count;
        res_nxt.table_full = add_full;
        res_nxt.running    = (add_count != '0)
                             && (loop_endless_r || (loops_r < loop_limit_r));
        state_nxt          = S_FIN;
      end
      S_READ: begin
        if (!tick_active) begin
          state_nxt = S_FIN;
        end else begin
          res_nxt.running     = 1'b1;
          res_nxt.rect_update = (timer_r == '0);
          res_nxt.flip        = (timer_r == '0) ? rdata_r.flp : 1'b0;
          if (frame_done) begin
            timer_nxt = '0;
            if (last_frame) begin
              index_nxt = '0;
              loops_nxt = (loops_r == LOOP_SAT) ? loops_r : loops_r + LOOP_W'(1);
            end else begin
              index_nxt = index_r + IDX_W'(1);
            end
          end else begin
            timer_nxt = timer_sum;
          end
          state_nxt = (timer_r == '0) ? S_MULX : S_FIN;
        end
      end
      S_MULX: begin
        res_nxt.src_x = mac;
        state_nxt     = S_MULY;
      end
      S_MULY: begin
        res_nxt.src_y = mac;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.running     = out_res_r.running;
  assign out_ch.rect_update = out_res_r.rect_update;
  assign out_ch.src_x       = out_res_r.src_x;
  assign out_ch.src_y       = out_res_r.src_y;
  assign out_ch.flip        = out_res_r.flip;
  assign out_ch.table_full  = out_res_r.table_full;

endmodule

### hw/rtl/sfs_checker.sv
module sfs_checker
  import sfs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             running,
  input logic             rect_update,
  input logic [SRC_W-1:0] src_x,
  input logic [SRC_W-1:0] src_y,
  input logic             flip,
  input logic             table_full
);

  // The block works on one word at a time, so it is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word was still in progress");

  // A dropped append never carries a frame origin.
  a_full_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && table_full |-> !rect_update && !flip && src_x == '0 && src_y == '0)
    else $error("append result carries a frame origin");

  // An origin is only emitted by a running sequencer.
  a_update_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rect_update |-> running && !table_full)
    else $error("frame origin emitted while not running");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(running) && $stable(rect_update)
      && $stable(src_x) && $stable(src_y) && $stable(flip) && $stable(table_full))
    else $error("stalled result changed");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .running     (out_ch.running),
  .rect_update (out_ch.rect_update),
  .src_x       (out_ch.src_x),
  .src_y       (out_ch.src_y),
  .flip        (out_ch.flip),
  .table_full  (out_ch.table_full)
);
